>>> hw/rtl/cave_automaton_smoothing_pass_core_assert.svh
// Assertion macros shared by the checker of the cave smoothing pass core.
`ifndef CAVE_AUTOMATON_SMOOTHING_PASS_CORE_ASSERT_SVH
`define CAVE_AUTOMATON_SMOOTHING_PASS_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define CASP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define CASP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

>>> hw/rtl/casp_pkg.sv
// Shared types and constants of the cave smoothing pass core.
`timescale 1ns / 1ps
package casp_pkg;

  // Largest supported row length in cells.
  localparam int MAX_WIDTH_DEFAULT = 256;

  // Smallest meaningful frame dimension and the wall count that keeps a cell.
  localparam int MIN_DIM        = 3;
  localparam int WALL_THRESHOLD = 4;

  // Register reset values.
  localparam logic [8:0]  FRAME_WIDTH_RESET  = 9'd64;
  localparam logic [15:0] FRAME_HEIGHT_RESET = 16'd64;

  // Register indexes on the configuration port.
  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // One result beat.
  typedef struct packed {
    logic        wall;
    logic [7:0]  col;
    logic [15:0] row;
    logic        last;
  } result_t;

endpackage

>>> hw/rtl/casp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module casp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/cave_automaton_smoothing_pass_core.sv
// Each result is computed from the accepted cell and registered in the output register.
// Throughput: one cell per cycle unless stalled; the line buffer RAM is read one column ahead.
// A result waiting under out_stall is parked in a skid register; input stalls only while it is full.
// Reset (synchronous): clears counters, window and handshake state; sizes return to 64.
// The line buffers are not cleared; every entry is written before it is used.
`timescale 1ns / 1ps
module cave_automaton_smoothing_pass_core
  import casp_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // Cell stream in
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cell_in,
  // Result stream out
  output logic        out_valid,
  input  logic        out_stall,
  output logic        cell_out,
  output logic [7:0]  out_col,
  output logic [15:0] out_row,
  output logic        last_cell,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = (CW + 1 > 9) ? CW + 1 : 9;
  localparam int XW = (CW > 8) ? CW : 8;

  logic [8:0]    frame_width;
  logic [15:0]   frame_height;
  logic [CW-1:0] col;
  logic [CW-1:0] col_next;
  logic [15:0]   row;
  logic [15:0]   row_next;
  logic [5:0]    window;
  logic [1:0]    line_rdata;
  logic          skid_valid;
  result_t       out_beat;
  result_t       skid_beat;
  result_t       res;
  logic          res_valid;
  logic          in_accept;
  logic          cfg_write;
  cfg_reg_t      cfg_sel;

  logic [EW-1:0] width_ext;
  logic [EW-1:0] width_eff;
  logic [CW-1:0] width_last;
  logic [15:0]   height_last;
  logic [2:0]    col_new;
  logic [2:0]    col_left;
  logic [2:0]    col_mid;
  logic [3:0]    walls;
  logic [XW-1:0] col_ext;

  // Configuration port: always ready, index taken from the word address.
  assign pready    = 1'b1;
  assign cfg_sel   = cfg_reg_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[8:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_FRAME_WIDTH:  prdata = {23'd0, frame_width};
      REG_FRAME_HEIGHT: prdata = {16'd0, frame_height};
      default:          prdata = 32'd0;
    endcase
  end

  // Effective frame size, clamped into the supported range.
  always_comb begin
    width_ext = EW'(frame_width);
    if (width_ext < EW'(MIN_DIM)) begin
      width_eff = EW'(MIN_DIM);
    end else if (width_ext > EW'(MAX_WIDTH)) begin
      width_eff = EW'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    width_last = CW'(width_eff - EW'(1));
    if (frame_height < 16'(MIN_DIM)) begin
      height_last = 16'(MIN_DIM - 1);
    end else begin
      height_last = frame_height - 16'd1;
    end
  end

  // Input side: a full skid register is the only reason to hold off.
  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !in_stall;

  // Raster position of the next cell.
  always_comb begin
    if (col >= width_last) begin
      col_next = '0;
      row_next = (row >= height_last) ? 16'd0 : row + 16'd1;
    end else begin
      col_next = col + CW'(1);
      row_next = row;
    end
  end

  // Two line buffers share one RAM: bit 1 two rows above, bit 0 one row above.
  // The read runs one column ahead, so its data belongs to the current column.
  casp_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (in_accept),
    .waddr (col),
    .wdata ({line_rdata[0], cell_in}),
    .re    (in_accept),
    .raddr (col_next),
    .rdata (line_rdata)
  );

  // 3x3 neighbourhood centred one row up and one column left.
  assign col_new  = {line_rdata, cell_in};
  assign col_left = window[5:3];
  assign col_mid  = window[2:0];

  assign walls = 4'(col_left[0]) + 4'(col_left[1]) + 4'(col_left[2])
               + 4'(col_new[0])  + 4'(col_new[1])  + 4'(col_new[2])
               + 4'(col_mid[0])  + 4'(col_mid[2]);

  // Smoothing rule and result fields.
  assign col_ext   = XW'(col);
  assign res_valid = in_accept && (row >= 16'd2) && (col >= CW'(2));

  always_comb begin
    if (walls > 4'(WALL_THRESHOLD)) begin
      res.wall = 1'b1;
    end else if (walls < 4'(WALL_THRESHOLD)) begin
      res.wall = 1'b0;
    end else begin
      res.wall = col_mid[1];
    end
    res.col  = 8'(col_ext - XW'(1));
    res.row  = row - 16'd1;
    res.last = (row == height_last) && (col == width_last);
  end

  // Position counters and the two-column window.
  always_ff @(posedge clk) begin
    if (rst) begin
      col    <= '0;
      row    <= '0;
      window <= '0;
    end else if (in_accept) begin
      col    <= col_next;
      row    <= row_next;
      window <= {col_mid, col_new};
    end
  end

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_beat <= skid_valid ? skid_beat : res;
    end else if (res_valid) begin
      skid_beat <= res;
    end
  end

  assign cell_out  = out_beat.wall;
  assign out_col   = out_beat.col;
  assign out_row   = out_beat.row;
  assign last_cell = out_beat.last;

endmodule

>>> hw/rtl/casp_checker.sv
// Port-level checker of the cave smoothing pass core, bound to the top level.
`timescale 1ns / 1ps
`include "cave_automaton_smoothing_pass_core_assert.svh"
module casp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_col,
  input logic [15:0] out_row
);

  // A stalled output beat stays offered.
  `CASP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // A stalled output beat keeps its position.
  `CASP_ASSERT_NEXT(a_out_pos_stable, out_valid && out_stall, $stable(out_row) && $stable(out_col))

  // The input is held off only while a result is waiting on the output.
  `CASP_ASSERT_NOW(a_stall_needs_beat, in_stall, out_valid)

  // Results are interior cells, so the row is never the top border.
  `CASP_ASSERT_NOW(a_row_interior, out_valid, out_row != 16'd0)

endmodule

bind cave_automaton_smoothing_pass_core casp_checker u_casp_checker (.*);

>>> tb/testbench.sv
// Self-checking testbench for the cave smoothing pass core.
`timescale 1ns / 1ps
module testbench
  import casp_pkg::*;
();

  localparam int ROW_BUFFER    = MAX_WIDTH_DEFAULT;
  localparam int IDLE_LIMIT    = 3000;
  localparam int CELL_TARGET   = 1150;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        cell_in = 1'b0;
  logic        out_stall = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic        in_stall;
  logic        out_valid;
  logic        cell_out;
  logic [7:0]  out_col;
  logic [15:0] out_row;
  logic        last_cell;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the block: line buffers, window, counters and registers.
  bit          row_two_above [ROW_BUFFER];
  bit          row_one_above [ROW_BUFFER];
  logic [5:0]  window_cols = 6'd0;
  logic [7:0]  col_pos = 8'd0;
  logic [15:0] row_pos = 16'd0;
  logic [8:0]  width_reg = FRAME_WIDTH_RESET;
  logic [15:0] height_reg = FRAME_HEIGHT_RESET;

  result_t     expected_cells [$];
  int          errors = 0;
  int          cells_sent = 0;
  int          idle_cycles = 0;
  bit          sender_idles = 1'b0;
  bit          receiver_idles = 1'b0;
  int          hold_requests = 0;
  int          holds_served = 0;
  int          hold_left = 0;
  int          stall_run = 0;

  cave_automaton_smoothing_pass_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .cell_in(cell_in),
    .out_valid(out_valid), .out_stall(out_stall), .cell_out(cell_out),
    .out_col(out_col), .out_row(out_row), .last_cell(last_cell),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Sizes as the block sees them, after clamping to the supported range.
  function automatic int active_width();
    if (width_reg < MIN_DIM) return MIN_DIM;
    if (width_reg > ROW_BUFFER) return ROW_BUFFER;
    return int'(width_reg);
  endfunction

  function automatic int active_height();
    return (height_reg < MIN_DIM) ? MIN_DIM : int'(height_reg);
  endfunction

  function automatic int wall_bits(logic [2:0] column);
    return column[0] + column[1] + column[2];
  endfunction

  // Advances the shadow by one cell and returns 1 when that cell completes an interior result.
  function automatic bit smooth_cell(input bit wall_in, output result_t res);
    int         w;
    int         h;
    int         walls;
    logic [2:0] col_new;
    logic [2:0] col_left;
    logic [2:0] col_mid;
    bit         produced;
    w = active_width();
    h = active_height();
    col_new = {row_two_above[col_pos], row_one_above[col_pos], wall_in};
    col_left = window_cols[5:3];
    col_mid = window_cols[2:0];
    produced = (row_pos >= 2) && (col_pos >= 2);
    res = '0;
    if (produced) begin
      // The centre itself is left out of the count.
      walls = wall_bits(col_left) + wall_bits(col_new) + wall_bits(col_mid & 3'b101);
      if (walls > WALL_THRESHOLD) res.wall = 1'b1;
      else if (walls < WALL_THRESHOLD) res.wall = 1'b0;
      else res.wall = col_mid[1];
      res.col = col_pos - 8'd1;
      res.row = row_pos - 16'd1;
      res.last = (int'(row_pos) == h - 1) && (int'(col_pos) == w - 1);
    end
    row_two_above[col_pos] = row_one_above[col_pos];
    row_one_above[col_pos] = wall_in;
    window_cols = {col_mid, col_new};
    // Counters at or past their limit wrap, so mid-frame size changes cannot stick them.
    if (int'(col_pos) >= w - 1) begin
      col_pos = 8'd0;
      if (int'(row_pos) >= h - 1) row_pos = 16'd0;
      else row_pos = row_pos + 16'd1;
    end else begin
      col_pos = col_pos + 8'd1;
    end
    return produced;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Predict on every accepted cell, then compare every accepted result beat.
  always @(posedge clk) begin
    result_t res;
    if (!rst) begin
      if (in_valid && !in_stall && smooth_cell(cell_in, res)) expected_cells.push_back(res);
      if (out_valid && !out_stall) begin
        if (expected_cells.size() == 0) begin
          errors++;
          $display("%0t ns: result beat with nothing expected (col %0d row %0d)",
                   $time, out_col, out_row);
        end else begin
          res = expected_cells.pop_front();
          check_field("cell_out", res.wall, cell_out);
          check_field("out_col", res.col, out_col);
          check_field("out_row", res.row, out_row);
          check_field("last_cell", res.last, last_cell);
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever a test asks for one.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_run > 0) begin
        stall_run--;
        out_stall <= 1'b1;
      end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
        stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: too long without any beat or register access ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly back-to-back, sometimes a short gap, rarely a long one.
  function automatic int pick_gap();
    int roll;
    if (!sender_idles) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offers one cell and returns at the edge where it is accepted.
  task automatic send_cell(input bit wall);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cell_in <= wall;
    do @(posedge clk); while (in_stall);
    cells_sent++;
  endtask

  // Sends a run of random cells with the given wall percentage, then drops valid.
  task automatic send_random(input int count, input int density);
    for (int i = 0; i < count; i++) send_cell($urandom_range(0, 99) < density);
    in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register transfer: a setup phase, then an access phase until pready.
  task automatic reg_transfer(input cfg_reg_t idx, input bit write, input logic [31:0] data,
                              output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
    logic [31:0] unused;
    drain_results();
    reg_transfer(idx, 1'b1, value, unused);
    if (idx == REG_FRAME_WIDTH) width_reg = value[8:0];
    else height_reg = value[15:0];
  endtask

  task automatic check_reg(input cfg_reg_t idx, input logic [31:0] want);
    logic [31:0] rdata;
    logic [31:0] mask;
    mask = (idx == REG_FRAME_WIDTH) ? 32'h1FF : 32'hFFFF;
    reg_transfer(idx, 1'b0, 32'd0, rdata);
    if ((rdata & mask) != (want & mask)) begin
      errors++;
      $display("%0t ns: register %s expected %0d, got %0d", $time, idx.name(),
               want & mask, rdata & mask);
    end
  endtask

  // Reset values, then every bit set and every bit clear, read back each time.
  task automatic test_register_access();
    check_reg(REG_FRAME_WIDTH, 32'(FRAME_WIDTH_RESET));
    check_reg(REG_FRAME_HEIGHT, 32'(FRAME_HEIGHT_RESET));
    write_reg(REG_FRAME_WIDTH, 32'h1FF);
    write_reg(REG_FRAME_HEIGHT, 32'hFFFF);
    check_reg(REG_FRAME_WIDTH, 32'h1FF);
    check_reg(REG_FRAME_HEIGHT, 32'hFFFF);
    write_reg(REG_FRAME_WIDTH, 32'd0);
    write_reg(REG_FRAME_HEIGHT, 32'd0);
    check_reg(REG_FRAME_WIDTH, 32'd0);
    check_reg(REG_FRAME_HEIGHT, 32'd0);
  endtask

  // Three 3x3 frames from undersized registers: all walls, then exactly four
  // wall neighbours around a wall centre and around an open centre.
  task automatic test_directed_frames();
    logic [26:0] cells;
    cells = 27'b111111111_111110000_010101010;
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    write_reg(REG_FRAME_WIDTH, 32'd2);
    write_reg(REG_FRAME_HEIGHT, 32'd1);
    for (int i = 26; i >= 0; i--) send_cell(cells[i]);
    in_valid <= 1'b0;
  endtask

  // An oversized width acts as the full row buffer; rows reach the last column.
  task automatic test_widest_rows();
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    write_reg(REG_FRAME_WIDTH, 32'h1FF);
    write_reg(REG_FRAME_HEIGHT, 32'd2);
    send_random(ROW_BUFFER * MIN_DIM, 50);
  endtask

  // Tallest frame, cut short by lowering the height in mid-frame so the row counter wraps.
  task automatic test_height_wrap();
    write_reg(REG_FRAME_WIDTH, 32'd4);
    write_reg(REG_FRAME_HEIGHT, 32'hFFFF);
    send_random(32, 50);
    write_reg(REG_FRAME_HEIGHT, 32'd5);
    send_random(24, 45);
  endtask

  // Narrowing the row while the column counter is past the new edge wraps that row.
  task automatic test_width_shrink();
    write_reg(REG_FRAME_WIDTH, 32'd10);
    write_reg(REG_FRAME_HEIGHT, 32'd6);
    send_random(37, 55);
    write_reg(REG_FRAME_WIDTH, 32'd5);
    send_random(11, 55);
  endtask

  // The receiver holds off for a long stretch while cells keep coming.
  task automatic test_backpressure();
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    write_reg(REG_FRAME_WIDTH, 32'd8);
    write_reg(REG_FRAME_HEIGHT, 32'd10);
    hold_requests++;
    send_random(80, 50);
  endtask

  // Whole frames of random small sizes and densities until enough cells have gone in.
  task automatic test_random_frames();
    int densities [5] = '{10, 35, 50, 65, 90};
    while (cells_sent < CELL_TARGET) begin
      write_reg(REG_FRAME_WIDTH, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                                              : $urandom_range(3, 12));
      write_reg(REG_FRAME_HEIGHT, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                                               : $urandom_range(3, 9));
      sender_idles = ($urandom_range(0, 3) != 0);
      receiver_idles = ($urandom_range(0, 3) != 0);
      send_random(active_width() * active_height(), densities[$urandom_range(0, 4)]);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_register_access();
    test_directed_frames();
    test_widest_rows();
    test_height_wrap();
    test_width_shrink();
    test_backpressure();
    test_random_frames();
    drain_results();
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
